>>> rtl/core/gbcs_pkg.sv
`timescale 1ns / 1ps

package gbcs_pkg;

   localparam int VAL_W  = 16;
   localparam int SUM_W  = 32;
   localparam int CNT_W  = 16;
   localparam int DIVR_W = CNT_W + 1;
   localparam int GAIN_W = 9;
   localparam int PROD_W = 24;
   localparam int AXES   = 3;
   localparam int AXIS_W = 2;
   localparam int STEP_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int SENS_W = 3;

   localparam logic OP_CALIB = 1'b0;
   localparam logic OP_RATE  = 1'b1;

   localparam logic KIND_RATE = 1'b0;
   localparam logic KIND_BIAS = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_SAMPLES = 2'd1;

   localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;

   localparam logic [SENS_W-1:0] SENS_SET0 = 3'd0;
   localparam logic [SENS_W-1:0] SENS_SET1 = 3'd1;
   localparam logic [SENS_W-1:0] SENS_SET2 = 3'd2;
   localparam logic [SENS_W-1:0] SENS_SET3 = 3'd3;
   localparam logic [SENS_W-1:0] SENS_SET4 = 3'd4;
   localparam logic [SENS_W-1:0] SENS_UNSUPPORTED = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SCALE,
      ST_OUT
   } state_type;

   // Roll and pitch share one gain, yaw runs at about half of it.
   function automatic logic [GAIN_W-1:0] gain_lookup(input logic [SENS_W-1:0] sel,
                                                     input logic [AXIS_W-1:0] axis);
      logic yaw;
      logic [GAIN_W-1:0] g;
      yaw = (axis == AXIS_YAW);
      case (sel)
         SENS_SET0: g = yaw ? 9'd128 : 9'd256;
         SENS_SET1: g = yaw ? 9'd63  : 9'd127;
         SENS_SET2: g = yaw ? 9'd84  : 9'd169;
         SENS_SET3: g = yaw ? 9'd34  : 9'd68;
         SENS_SET4: g = yaw ? 9'd5   : 9'd11;
         default:   g = '0;
      endcase
      return g;
   endfunction

endpackage

>>> rtl/core/gbcs_if.sv
`timescale 1ns / 1ps

interface gbcs_req_if;
   logic              valid;
   logic              ready;
   logic              operation;
   logic signed [15:0] roll_sample;
   logic signed [15:0] pitch_sample;
   logic signed [15:0] yaw_sample;

   modport source (output valid, operation, roll_sample, pitch_sample, yaw_sample,
                   input ready);
   modport sink   (input valid, operation, roll_sample, pitch_sample, yaw_sample,
                   output ready);
endinterface

interface gbcs_rsp_if;
   logic              valid;
   logic              ready;
   logic              result_kind;
   logic signed [15:0] roll_value;
   logic signed [15:0] pitch_value;
   logic signed [15:0] yaw_value;

   modport source (output valid, result_kind, roll_value, pitch_value, yaw_value,
                   input ready);
   modport sink   (input valid, result_kind, roll_value, pitch_value, yaw_value,
                   output ready);
endinterface

interface gbcs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/gbcs_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Keeps the low quotient bits only.
module gbcs_div import gbcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic              done,
   output logic [VAL_W-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dvr_ff, dvr_in;
   logic [VAL_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   diff;
   logic              qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, dvd_ff[SUM_W-1]};
      diff    = trial - {1'b0, dvr_ff};
      qbit    = (trial >= {1'b0, dvr_ff});
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W - 1);
         dvd_in  = dividend;
         rem_in  = '0;
         dvr_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits back in DIVR_W bits
         rem_in = qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
         quo_in = {quo_ff[VAL_W-2:0], qbit};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvr_ff  <= dvr_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/gbcs_scale.sv
`timescale 1ns / 1ps

// Bias removal with 16-bit wrap, gain multiply, arithmetic shift right by 8.
module gbcs_scale import gbcs_pkg::*; (
   input  logic signed [VAL_W-1:0] sample,
   input  logic        [VAL_W-1:0] bias,
   input  logic       [GAIN_W-1:0] gain,
   output logic signed [VAL_W-1:0] rate
);

   logic signed [VAL_W-1:0]  diff;
   logic signed [GAIN_W:0]   gain_s;
   logic signed [PROD_W-1:0] prod;

   always_comb begin
      diff   = sample - $signed(bias);
      gain_s = $signed({1'b0, gain});
      // gains from gain_lookup are <= 256, so |diff * gain| <= 2^23 and the product fits PROD_W bits
      prod   = diff * gain_s;
      rate   = prod[PROD_W-1:PROD_W-VAL_W];
   end

endmodule

>>> rtl/core/gyro_bias_calibrate_and_scale_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                        Handshake
// req      in   operation, roll/pitch/yaw_sample (s16)         valid/ready
// rsp      out  result_kind, roll/pitch/yaw_value (s16)        valid/ready
// csr      in   index (2b), data (16b): 0 sensor_type,         valid/ready
//               1 calib_samples
//
// A rate item is paced by the one shared gain multiplier walking the three axes;
// with an unsupported sensor type it skips the multiplier. A calibration item
// that closes the average also runs the bit-serial divider once per axis.
// Reset is synchronous, active high, and returns sums, count, biases and last
// rates to zero, sensor_type to 5 and calib_samples to 1.
// The result sits in an output register: a new item is taken while it waits, and
// a stalled rsp only holds the sequencer in its final step.
module gyro_bias_calibrate_and_scale_top import gbcs_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   gbcs_req_if.sink   req,
   gbcs_rsp_if.source rsp,
   gbcs_csr_if.sink   csr
);

   localparam int SH = VAL_W - SAMPLE_BITS;

   state_type state_ff, state_in;

   logic [AXIS_W-1:0]       axis_ff, axis_in;
   logic                    op_ff, op_in;
   logic                    final_ff, final_in;
   logic [DIVR_W-1:0]       divisor_ff, divisor_in;
   logic signed [VAL_W-1:0] smp_ff [AXES];
   logic signed [VAL_W-1:0] smp_in [AXES];
   logic [SUM_W-1:0]        sums_ff [AXES];
   logic [SUM_W-1:0]        sums_in [AXES];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [VAL_W-1:0]        bias_ff [AXES];
   logic [VAL_W-1:0]        bias_in [AXES];
   logic [VAL_W-1:0]        rates_ff [AXES];
   logic [VAL_W-1:0]        rates_in [AXES];
   logic [SENS_W-1:0]       sensor_type_ff, sensor_type_in;
   logic [CNT_W-1:0]        calib_ff, calib_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [VAL_W-1:0]        rsp_val_ff [AXES];
   logic [VAL_W-1:0]        rsp_val_in [AXES];

   // control strobes
   logic req_ready;
   logic csr_ready;
   logic req_take;
   logic csr_take;
   logic out_free;
   logic out_load;
   logic acc_en;
   logic div_start;
   logic div_wait;
   logic scale_en;
   logic supported;

   // per-item decode
   logic signed [VAL_W-1:0] raw [AXES];
   logic signed [VAL_W-1:0] shifted;
   logic [DIVR_W-1:0]       n_next;
   logic [DIVR_W-1:0]       target;

   // shared units
   logic [SUM_W-1:0]        sum_sel;
   logic [SUM_W-1:0]        sum_mag;
   logic                    div_done;
   logic [VAL_W-1:0]        div_quo;
   logic [VAL_W-1:0]        bias_sel;
   logic [GAIN_W-1:0]       gain_sel;
   logic signed [VAL_W-1:0] rate_out;

   assign supported = sensor_type_ff inside {[SENS_SET0:SENS_SET4]};
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req_take  = req.valid && req_ready;
   assign csr_take  = csr.valid && csr_ready;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req.operation == OP_CALIB) state_in = ST_ACC;
               else if (supported)            state_in = ST_SCALE;
               else                           state_in = ST_OUT;
            end
         end
         ST_ACC: begin
            if (axis_ff == AXIS_YAW) state_in = final_ff ? ST_DIV_START : ST_IDLE;
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) state_in = (axis_ff == AXIS_YAW) ? ST_OUT : ST_DIV_START;
         end
         ST_SCALE: begin
            if (axis_ff == AXIS_YAW) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------- outputs
   always_comb begin
      req_ready = 1'b0;
      acc_en    = 1'b0;
      div_start = 1'b0;
      div_wait  = 1'b0;
      scale_en  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:      req_ready = !reset;
         ST_ACC:       acc_en    = 1'b1;
         ST_DIV_START: div_start = 1'b1;
         ST_DIV_WAIT:  div_wait  = 1'b1;
         ST_SCALE:     scale_en  = 1'b1;
         ST_OUT:       out_load  = out_free;
         default:      req_ready = 1'b0;
      endcase
   end

   assign csr_ready = !reset;

   // ---------------------------------------------------------- sample decode
   // Keep the low SAMPLE_BITS bits and sign-extend from the top one of them.
   assign raw[AXIS_ROLL]  = req.roll_sample;
   assign raw[AXIS_PITCH] = req.pitch_sample;
   assign raw[AXIS_YAW]   = req.yaw_sample;

   always_comb begin
      shifted = '0;
      for (int a = 0; a < AXES; a++) begin
         shifted   = raw[a] <<< SH;
         smp_in[a] = shifted >>> SH;
      end
   end

   // A zero calib_samples register asks for 65536 samples.
   assign n_next = {1'b0, count_ff} + 1'b1;
   assign target = (calib_ff == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, calib_ff};

   // ------------------------------------------------------------- shared units
   assign sum_sel  = sums_ff[axis_ff];
   assign sum_mag  = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
   assign bias_sel = bias_ff[axis_ff];
   assign gain_sel = gain_lookup(sensor_type_ff, axis_ff);

   gbcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   gbcs_scale u_scale (
      .sample (smp_ff[axis_ff]),
      .bias   (bias_sel),
      .gain   (gain_sel),
      .rate   (rate_out)
   );

   // ----------------------------------------------------------------- datapath
   always_comb begin
      axis_in        = axis_ff;
      op_in          = op_ff;
      final_in       = final_ff;
      divisor_in     = divisor_ff;
      count_in       = count_ff;
      sensor_type_in = sensor_type_ff;
      calib_in       = calib_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      sums_in        = sums_ff;
      bias_in        = bias_ff;
      rates_in       = rates_ff;
      rsp_val_in     = rsp_val_ff;

      // latch the item and decide now whether it closes the average
      if (req_take) begin
         op_in      = req.operation;
         final_in   = (n_next >= target);
         divisor_in = n_next;
         axis_in    = AXIS_ROLL;
      end

      // advance one axis per step of the shared unit
      if (acc_en || scale_en || (div_wait && div_done)) begin
         axis_in = (axis_ff == AXIS_YAW) ? AXIS_ROLL : axis_ff + 1'b1;
      end

      if (acc_en) begin
         sums_in[axis_ff] = sum_sel + {{(SUM_W-VAL_W){smp_ff[axis_ff][VAL_W-1]}},
                                       smp_ff[axis_ff]};
         if (axis_ff == AXIS_YAW && !final_ff) count_in = divisor_ff[CNT_W-1:0];
      end

      if (div_wait && div_done) begin
         bias_in[axis_ff] = sum_sel[SUM_W-1] ? (~div_quo + 1'b1) : div_quo;
         sums_in[axis_ff] = '0;
         if (axis_ff == AXIS_YAW) count_in = '0;
      end

      if (scale_en) rates_in[axis_ff] = rate_out;

      // output register: load on the final step, drop once taken
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (op_ff == OP_CALIB) begin
            rsp_kind_in = KIND_BIAS;
            rsp_val_in  = bias_ff;
         end else begin
            rsp_kind_in = KIND_RATE;
            rsp_val_in  = rates_ff;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_take) begin
         case (csr.index)
            CSR_SENSOR_TYPE:   sensor_type_in = csr.data[SENS_W-1:0];
            CSR_CALIB_SAMPLES: calib_in       = csr.data;
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         axis_ff        <= AXIS_ROLL;
         count_ff       <= '0;
         sensor_type_ff <= SENS_UNSUPPORTED;
         calib_ff       <= CNT_W'(1);
         rsp_valid_ff   <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            sums_ff[a]  <= '0;
            bias_ff[a]  <= '0;
            rates_ff[a] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         axis_ff        <= axis_in;
         count_ff       <= count_in;
         sensor_type_ff <= sensor_type_in;
         calib_ff       <= calib_in;
         rsp_valid_ff   <= rsp_valid_in;
         sums_ff        <= sums_in;
         bias_ff        <= bias_in;
         rates_ff       <= rates_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      final_ff    <= final_in;
      divisor_ff  <= divisor_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_val_ff  <= rsp_val_in;
      if (req_take) smp_ff <= smp_in;
   end

   assign req.ready       = req_ready;
   assign csr.ready       = csr_ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = rsp_kind_ff;
   assign rsp.roll_value  = rsp_val_ff[AXIS_ROLL];
   assign rsp.pitch_value = rsp_val_ff[AXIS_PITCH];
   assign rsp.yaw_value   = rsp_val_ff[AXIS_YAW];

endmodule

>>> rtl/core/gbcs_checker.sv
`timescale 1ns / 1ps

module gbcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [15:0] rsp_roll
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_roll))
      else $error("rsp payload changed while stalled");

   // the block is busy in the cycle after it takes an item
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken on consecutive cycles");

   // a result is only loaded from a busy step, never while idle
   a_load_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp loaded while the block was idle");

endmodule

bind gyro_bias_calibrate_and_scale_top gbcs_checker u_gbcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_kind  (rsp.result_kind),
   .rsp_roll  (rsp.roll_value)
);
